FILE: rtl/core/bsp_pkg.sv
`timescale 1ns / 1ps

package bsp_pkg;

	// Width of a node number on the ports
	localparam int NODE_W = 6;

	// Default graph size
	localparam int NODES_DEFAULT = 64;

	// Command codes on op
	localparam logic OP_ADD_EDGE = 1'b0;
	localparam logic OP_QUERY    = 1'b1;

	// A path never runs past this many results before the final one
	localparam logic [NODE_W-1:0] PATH_CAP = 6'd63;

endpackage

FILE: rtl/core/bsp_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
// Read-before-write is never relied on: a fresh entry is read after its write.
module bsp_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/bsp_adj_mem.sv
`timescale 1ns / 1ps

// Adjacency matrix: one row per source node, bit j of row i is edge i->j.
// Per-row valid bits stand in for clearing the array at reset.
module bsp_adj_mem #(
	parameter int NODES = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(NODES)-1:0] waddr,
	input  logic [NODES-1:0]         wdata,
	input  logic [$clog2(NODES)-1:0] raddr,
	output logic [NODES-1:0]         rdata
);

	logic [NODES-1:0] mem [NODES];
	logic [NODES-1:0] row_s1;
	logic [NODES-1:0] valid_q;
	logic             row_valid_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		row_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			row_valid_s1 <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			row_valid_s1 <= valid_q[raddr];
		end
	end

	// A row never written reads as no edges
	assign rdata = row_valid_s1 ? row_s1 : '0;

endmodule

FILE: rtl/core/bsp_lsb_enc.sv
`timescale 1ns / 1ps

// Lowest set bit finder.
module bsp_lsb_enc #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0]         vec,
	output logic                     any,
	output logic [$clog2(WIDTH)-1:0] idx
);

	always_comb begin
		idx = '0;
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = ($clog2(WIDTH))'(i);
			end
		end
	end

	assign any = |vec;

endmodule

FILE: rtl/core/bfs_shortest_path_core.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload                   Transfer at
// -------   ---------------------   -----------------------   ------------------------
// command   start in, busy out      op, from_node, to_node    edge with start && !busy
// result    result_valid out        path_node, found, last    every edge with result_valid
//
// Edge add: read of the adjacency row, then write back with the new bit.
// Query: a setup step, then per dequeued node a queue read, a row read and a row
// check, plus a scan step per newly discovered neighbor and one to close the row;
// the path then comes out one node per predecessor read.
// The single-port reads of the queue, adjacency and predecessor memories set these.
// Reset clears the control state and the adjacency row valid bits; no sweep is run.
// busy stays high from a transfer until its last result, or an edge add's write, is
// registered; results appear for one cycle each and the receiver cannot stall them.
module bfs_shortest_path_core
	import bsp_pkg::*;
#(
	parameter int NODES = NODES_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              op,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	output logic              result_valid,
	output logic [NODE_W-1:0] path_node,
	output logic              found,
	output logic              last
);

	localparam int AW = $clog2(NODES);

	// Sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EDGE  = 4'd1;  // row data back, write it with the new edge
	localparam logic [3:0] S_DEQ   = 4'd2;  // pop the queue head or give up
	localparam logic [3:0] S_QWAIT = 4'd3;  // queue data back, fetch its row
	localparam logic [3:0] S_ROW   = 4'd4;  // row back, target check
	localparam logic [3:0] S_SCAN  = 4'd5;  // one new neighbor per cycle
	localparam logic [3:0] S_TRACE = 4'd6;  // emit a path node
	localparam logic [3:0] S_TWAIT = 4'd7;  // predecessor data back
	localparam logic [3:0] S_MISS  = 4'd8;  // emit the not-found result

	logic [3:0]        state_q;
	logic [NODE_W-1:0] from_q;
	logic [NODE_W-1:0] to_q;
	logic              tgt_in_q;
	logic [AW-1:0]     curr_q;
	logic [AW-1:0]     node_q;
	logic [NODE_W-1:0] count_q;
	logic [AW:0]       head_q;
	logic [AW:0]       tail_q;
	logic [NODES-1:0]  visited_q;
	logic [NODES-1:0]  has_pred_q;
	logic [NODES-1:0]  mask_q;

	logic              result_valid_q;
	logic [NODE_W-1:0] path_node_q;
	logic              found_q;
	logic              last_q;

	// Memory ports
	logic              adj_we;
	logic [AW-1:0]     adj_waddr;
	logic [NODES-1:0]  adj_wdata;
	logic [AW-1:0]     adj_raddr;
	logic [NODES-1:0]  adj_rdata;

	logic              q_we;
	logic [AW-1:0]     q_waddr;
	logic [AW-1:0]     q_wdata;
	logic [AW-1:0]     q_rdata;

	logic              pred_we;
	logic [AW-1:0]     pred_waddr;
	logic [AW-1:0]     pred_rdata;

	logic              enc_any;
	logic [AW-1:0]     enc_idx;

	logic              accept;
	logic              from_in;
	logic              to_in;
	logic [AW-1:0]     tgt_a;
	logic              row_hit;
	logic              more;

	assign accept  = start && (state_q == S_IDLE);
	assign from_in = {1'b0, from_node} < (NODE_W + 1)'(NODES);
	assign to_in   = {1'b0, to_node} < (NODE_W + 1)'(NODES);
	assign tgt_a   = to_q[AW-1:0];

	// Target reached when it shows up anywhere in the scanned row, visited or not
	assign row_hit = tgt_in_q && adj_rdata[tgt_a];

	// Another hop back toward the source exists and the path cap is not reached
	assign more = has_pred_q[node_q] && (count_q != PATH_CAP);

	// ---------------------------------------------------------------------
	// Memory request steering
	// ---------------------------------------------------------------------
	assign adj_raddr = (state_q == S_QWAIT) ? q_rdata : from_node[AW-1:0];
	assign adj_we    = (state_q == S_EDGE);
	assign adj_waddr = from_q[AW-1:0];
	assign adj_wdata = adj_rdata | (NODES'(1) << to_q[AW-1:0]);

	always_comb begin
		q_we    = 1'b0;
		q_waddr = tail_q[AW-1:0];
		q_wdata = enc_idx;
		if (accept && op == OP_QUERY && from_in) begin
			// Source seeds the queue at slot zero
			q_we    = 1'b1;
			q_waddr = '0;
			q_wdata = from_node[AW-1:0];
		end else if (state_q == S_SCAN && enc_any) begin
			q_we = 1'b1;
		end
	end

	always_comb begin
		pred_we    = 1'b0;
		pred_waddr = enc_idx;
		if (state_q == S_ROW && row_hit && !visited_q[tgt_a]) begin
			pred_we    = 1'b1;
			pred_waddr = tgt_a;
		end else if (state_q == S_SCAN && enc_any) begin
			pred_we = 1'b1;
		end
	end

	bsp_adj_mem #(
		.NODES(NODES)
	) u_adj (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	bsp_ram #(
		.DEPTH(NODES),
		.WIDTH(AW)
	) u_queue (
		.clk  (clk),
		.we   (q_we),
		.waddr(q_waddr),
		.wdata(q_wdata),
		.raddr(head_q[AW-1:0]),
		.rdata(q_rdata)
	);

	bsp_ram #(
		.DEPTH(NODES),
		.WIDTH(AW)
	) u_pred (
		.clk  (clk),
		.we   (pred_we),
		.waddr(pred_waddr),
		.wdata(curr_q),
		.raddr(node_q),
		.rdata(pred_rdata)
	);

	// Picks the lowest unvisited neighbor left in the row
	bsp_lsb_enc #(
		.WIDTH(NODES)
	) u_enc (
		.vec(mask_q),
		.any(enc_any),
		.idx(enc_idx)
	);

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			head_q         <= '0;
			tail_q         <= '0;
			visited_q      <= '0;
			has_pred_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == OP_ADD_EDGE) begin
							// Edges naming a node outside the graph are dropped
							if (from_in && to_in) begin
								state_q <= S_EDGE;
							end
						end else begin
							has_pred_q <= '0;
							head_q     <= '0;
							if (from_in) begin
								visited_q <= NODES'(1) << from_node[AW-1:0];
								tail_q    <= (AW + 1)'(1);
								state_q   <= S_DEQ;
							end else begin
								visited_q <= '0;
								tail_q    <= '0;
								state_q   <= S_MISS;
							end
						end
					end
				end
				S_EDGE: begin
					state_q <= S_IDLE;
				end
				S_DEQ: begin
					if (head_q == tail_q) begin
						state_q <= S_MISS;
					end else begin
						head_q  <= head_q + 1'b1;
						state_q <= S_QWAIT;
					end
				end
				S_QWAIT: begin
					state_q <= S_ROW;
				end
				S_ROW: begin
					if (row_hit) begin
						if (!visited_q[tgt_a]) begin
							visited_q[tgt_a]  <= 1'b1;
							has_pred_q[tgt_a] <= 1'b1;
						end
						state_q <= S_TRACE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (enc_any) begin
						visited_q[enc_idx]  <= 1'b1;
						has_pred_q[enc_idx] <= 1'b1;
						tail_q              <= tail_q + 1'b1;
					end else begin
						state_q <= S_DEQ;
					end
				end
				S_TRACE: begin
					result_valid_q <= 1'b1;
					state_q        <= more ? S_TWAIT : S_IDLE;
				end
				S_TWAIT: begin
					state_q <= S_TRACE;
				end
				S_MISS: begin
					result_valid_q <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			from_q   <= from_node;
			to_q     <= to_node;
			tgt_in_q <= to_in;
		end
		if (state_q == S_QWAIT) begin
			curr_q <= q_rdata;
		end
		if (state_q == S_ROW) begin
			// Visited nodes never re-enter the queue
			mask_q  <= adj_rdata & ~visited_q;
			node_q  <= tgt_a;
			count_q <= '0;
		end
		if (state_q == S_SCAN && enc_any) begin
			mask_q[enc_idx] <= 1'b0;
		end
		if (state_q == S_TWAIT) begin
			node_q <= pred_rdata;
		end
		if (state_q == S_TRACE) begin
			path_node_q <= NODE_W'(node_q);
			found_q     <= 1'b1;
			last_q      <= !more;
			count_q     <= count_q + 1'b1;
		end
		if (state_q == S_MISS) begin
			path_node_q <= to_q;
			found_q     <= 1'b0;
			last_q      <= 1'b1;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign path_node    = path_node_q;
	assign found        = found_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	// A miss is always a single, final result
	a_miss_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> last)
		else $error("not-found result without last");

	// Each non-final path node is followed by a predecessor read, then the next node
	a_path_cadence: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> !result_valid ##1 result_valid)
		else $error("path result missing after a non-final node");

	// Queue pointers stay ordered and inside the queue
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q && tail_q <= (AW + 1)'(NODES))
		else $error("queue pointer out of range");

	// Every node with a predecessor has been visited
	a_pred_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(has_pred_q & ~visited_q) == '0)
		else $error("predecessor set on an unvisited node");

	// Every result comes from a trace or miss step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q) == S_TRACE || $past(state_q) == S_MISS)
		else $error("result without a trace or miss step");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Shortest-path core check: every accepted command goes into a scoreboard that
// keeps its own copy of the adjacency matrix, runs the same breadth-first
// search and queues the path beats the core should emit. Each result strobe is
// compared field by field against the oldest queued beat.
module testbench;
	import bsp_pkg::*;

	localparam int RANDOM_ITEMS = 90;
	// commands near the end of the run go back to back
	localparam int QUIET_TAIL   = 20;
	// cycles to watch for stray results once nothing is pending
	localparam int SETTLE       = 40;

	// one result beat of a query
	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic              found;
		logic              last;
	} path_beat_t;

	// Mirrors the graph and predicts the beats of each query.
	class path_scoreboard;
		bit [NODES_DEFAULT-1:0] adj_rows [NODES_DEFAULT];
		path_beat_t             pending [$];
		int unsigned            mismatches, beats_seen, edges_added, queries;
		int unsigned            paths_found, longest_path;

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		// accepted command: update the graph, or search and queue the path
		function void note_command(logic opv, logic [NODE_W-1:0] src,
				logic [NODE_W-1:0] dst);
			bit [NODES_DEFAULT-1:0] seen, linked, row;
			bit [NODE_W-1:0]        parent [NODES_DEFAULT];
			bit [NODE_W-1:0]        fifo [NODES_DEFAULT];
			int                     head, tail, hops, cur;
			bit                     hit, more;
			path_beat_t             beat;
			if (opv == OP_ADD_EDGE) begin
				if (src < NODES_DEFAULT && dst < NODES_DEFAULT)
					adj_rows[src][dst] = 1'b1;
				edges_added++;
				return;
			end
			queries++;
			seen   = '0;
			linked = '0;
			head   = 0;
			tail   = 0;
			hit    = 1'b0;
			if (src < NODES_DEFAULT) begin
				seen[src] = 1'b1;
				fifo[0]   = src;
				tail      = 1;
			end
			// the search ends on the first scanned neighbor equal to the target,
			// visited or not, so a source only finds itself through a cycle
			while (!hit && head < tail && head < NODES_DEFAULT) begin
				cur = fifo[head];
				row = adj_rows[cur];
				head++;
				for (int j = 0; j < NODES_DEFAULT; j++) begin
					if (row[j]) begin
						if (!seen[j]) begin
							seen[j]   = 1'b1;
							linked[j] = 1'b1;
							parent[j] = NODE_W'(cur);
							if (tail < NODES_DEFAULT) begin
								fifo[tail] = NODE_W'(j);
								tail++;
							end
						end
						if (j == dst) begin
							hit = 1'b1;
							break;
						end
					end
				end
			end
			if (!hit) begin
				beat = '{dst, 1'b0, 1'b1};
				pending.insert(pending.size(), beat);
				return;
			end
			// walk the predecessor links from the target back to the source
			paths_found++;
			cur  = dst;
			hops = 0;
			do begin
				more = linked[cur] && hops < PATH_CAP;
				beat = '{NODE_W'(cur), 1'b1, !more};
				pending.insert(pending.size(), beat);
				hops++;
				cur = parent[cur];
			end while (more);
			if (hops > longest_path)
				longest_path = hops;
		endfunction

		task check_beat(logic [NODE_W-1:0] node, logic fnd, logic lst);
			path_beat_t want;
			beats_seen++;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result node %0d found %b last %b with nothing pending",
					node, fnd, lst));
				return;
			end
			want = pending.pop_front();
			if (node !== want.node)
				report_mismatch($sformatf("path_node %0d, want %0d", node, want.node));
			if (fnd !== want.found)
				report_mismatch($sformatf("found %b, want %b (node %0d)", fnd, want.found,
					want.node));
			if (lst !== want.last)
				report_mismatch($sformatf("last %b, want %b (node %0d)", lst, want.last,
					want.node));
		endtask

		task finish_check();
			if (pending.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", pending.size()));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              op = OP_ADD_EDGE;
	logic [NODE_W-1:0] from_node = '0;
	logic [NODE_W-1:0] to_node = '0;
	logic              result_valid;
	logic [NODE_W-1:0] path_node;
	logic              found;
	logic              last;

	path_scoreboard sb;
	int             sent;
	int             directed_count;
	bit             gaps_on;
	bit             quiet;
	bit             long_done;

	bfs_shortest_path_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.from_node    (from_node),
		.to_node      (to_node),
		.result_valid (result_valid),
		.path_node    (path_node),
		.found        (found),
		.last         (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Transfers and results are both sampled on the rising edge, where the
	// core's registered outputs still hold their pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_command(op, from_node, to_node);
			if (result_valid)
				sb.check_beat(path_node, found, last);
		end
	end

	// Present one command and return at the edge that transfers it. A random
	// gap with start low may go first; start is only touched once per edge.
	task automatic send_command(input logic opv, input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b);
		if (gaps_on && !quiet && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		op        <= opv;
		from_node <= a;
		to_node   <= b;
		start     <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sent++;
	endtask

	// hold off until every predicted beat has come out
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending.size() != 0);
	endtask

	// Well-formed input: a chain of distinct random nodes, then a query from
	// its head to its tail and sometimes one between two of its members.
	// A broken chain drops one edge so the end may not be reachable.
	task automatic run_chain(input int len, input bit broken);
		logic [NODE_W-1:0] chain [$];
		logic [NODE_W-1:0] pick;
		bit [NODES_DEFAULT-1:0] used;
		int gap_at;
		used = '0;
		while (chain.size() < len) begin
			pick = NODE_W'($urandom_range(0, NODES_DEFAULT - 1));
			if (!used[pick]) begin
				used[pick] = 1'b1;
				chain.insert(chain.size(), pick);
			end
		end
		gap_at = broken ? $urandom_range(0, len - 2) : -1;
		for (int i = 0; i < len - 1; i++)
			if (i != gap_at)
				send_command(OP_ADD_EDGE, chain[i], chain[i + 1]);
		send_command(OP_QUERY, chain[0], chain[len - 1]);
		if ($urandom_range(0, 1))
			send_command(OP_QUERY, chain[$urandom_range(0, len - 1)],
				chain[$urandom_range(0, len - 1)]);
	endtask

	initial begin
		sb        = new();
		sent      = 0;
		gaps_on   = 1'b1;
		quiet     = 1'b0;
		long_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// empty graph: nothing reachable, not even the source itself
		send_command(OP_QUERY, 6'd0, 6'd0);
		send_command(OP_QUERY, 6'd63, 6'd0);
		// self loop: source found as its own one-node path
		send_command(OP_ADD_EDGE, 6'd0, 6'd0);
		send_command(OP_QUERY, 6'd0, 6'd0);
		// two-node cycle between the extreme nodes
		send_command(OP_ADD_EDGE, 6'd0, 6'd63);
		send_command(OP_ADD_EDGE, 6'd63, 6'd0);
		send_command(OP_QUERY, 6'd0, 6'd63);
		send_command(OP_QUERY, 6'd63, 6'd63);
		send_command(OP_QUERY, 6'd63, 6'd0);
		// multi-hop chain, then the unreachable reverse direction
		send_command(OP_ADD_EDGE, 6'd1, 6'd2);
		send_command(OP_ADD_EDGE, 6'd2, 6'd3);
		send_command(OP_ADD_EDGE, 6'd3, 6'd4);
		send_command(OP_ADD_EDGE, 6'd4, 6'd62);
		send_command(OP_QUERY, 6'd1, 6'd62);
		send_command(OP_QUERY, 6'd62, 6'd1);
		send_command(OP_QUERY, 6'd5, 6'd5);
		// alternating bit patterns on both node fields
		send_command(OP_ADD_EDGE, 6'd42, 6'd21);
		send_command(OP_QUERY, 6'd42, 6'd21);
		send_command(OP_ADD_EDGE, 6'd21, 6'd42);
		send_command(OP_QUERY, 6'd21, 6'd21);
		directed_count = sent;
		// let the core run dry before the random part starts
		wait_drained();

		// --- random ---
		while (sent < directed_count + RANDOM_ITEMS) begin
			quiet   = (sent >= directed_count + RANDOM_ITEMS - QUIET_TAIL);
			gaps_on = ($urandom_range(0, 2) != 0);
			case ($urandom_range(0, 9))
				0, 1: begin
					// noise: random edges and random queries
					repeat ($urandom_range(1, 3))
						send_command($urandom_range(0, 1) ? OP_QUERY : OP_ADD_EDGE,
							NODE_W'($urandom_range(0, NODES_DEFAULT - 1)),
							NODE_W'($urandom_range(0, NODES_DEFAULT - 1)));
				end
				2: begin
					if (!long_done) begin
						run_chain(20, 1'b0);
						long_done = 1'b1;
					end else begin
						run_chain(3, 1'b1);
					end
				end
				3: run_chain($urandom_range(2, 5), 1'b1);
				default: run_chain($urandom_range(2, 6), 1'b0);
			endcase
			if (!quiet && $urandom_range(0, 4) == 0)
				wait_drained();
		end

		// --- wind down ---
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending.size() != 0);
		repeat (SETTLE) @(posedge clk);
		sb.finish_check();

		$display("ran %0d commands: %0d edge adds, %0d queries (%0d found, %0d not found)",
			sent, sb.edges_added, sb.queries, sb.paths_found,
			sb.queries - sb.paths_found);
		$display("checked %0d result beats, longest path %0d nodes",
			sb.beats_seen, sb.longest_path);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// worst case is far below this, even at ~150 commands
	initial begin
		#1000000;
		$display("timeout waiting on the core");
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: bfs_shortest_path_core.f
rtl/core/bsp_pkg.sv
rtl/core/bsp_ram.sv
rtl/core/bsp_adj_mem.sv
rtl/core/bsp_lsb_enc.sv
rtl/core/bfs_shortest_path_core.sv
tb/testbench.sv
